@@ sv/dsvfs_pkg.sv @@
// shared types and constants for the delimiter-separated value splitter
package dsvfs_pkg;

    localparam logic [7:0] QUOTE_BYTE     = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
    localparam logic [7:0] DELIMITER_RST  = 8'd44;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_END  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_CELL_END = 2'd1,
        KIND_ROW_END  = 2'd2
    } t_kind;

    // one result heading for the output register
    typedef struct packed {
        logic       load;
        t_kind      kind;
        logic [7:0] value;
    } t_result;

endpackage

@@ sv/dsvfs_in_reg.sv @@
// input register stage holding one request
module dsvfs_in_reg import dsvfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_byte_req,
    input  logic       i_consume,
    output logic       o_valid,
    output t_action    o_action,
    output logic [7:0] o_byte_req
);

    logic       r_valid;
    t_action    r_action;
    logic [7:0] r_byte_req;
    logic       w_take;

    assign o_stall = r_valid && !i_consume;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action   <= t_action'(i_action);
            r_byte_req <= i_byte_req;
        end
    end

    assign o_valid    = r_valid;
    assign o_action   = r_action;
    assign o_byte_req = r_byte_req;

endmodule

@@ sv/dsvfs_parse.sv @@
// quoting and row state with the per-byte parse decision
module dsvfs_parse import dsvfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  t_action    i_action,
    input  logic [7:0] i_byte_req,
    input  logic       i_out_free,
    output logic       o_consume,
    output t_result    o_result
);

    logic [7:0] r_delimiter;
    logic       r_in_quotes;
    logic       r_quote_pending;
    logic [7:0] r_prev_byte;
    logic       r_line_start;

    logic       n_in_quotes;
    logic       n_quote_pending;
    logic [7:0] n_prev_byte;
    logic       n_line_start;

    logic       w_res_valid;
    t_kind      w_kind;
    logic [7:0] w_value;
    logic       w_inq;
    logic       w_done;

    always_comb begin
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_prev_byte     = r_prev_byte;
        n_line_start    = r_line_start;
        w_res_valid     = 1'b0;
        w_kind          = KIND_BYTE;
        w_value         = 8'd0;
        w_inq           = r_in_quotes;
        w_done          = 1'b0;
        if (i_action == ACT_END || i_byte_req == NEWLINE_BYTE) begin
            // end of source with an empty row gives nothing
            w_res_valid     = (i_action == ACT_BYTE) || !r_line_start;
            w_kind          = KIND_ROW_END;
            n_in_quotes     = 1'b0;
            n_quote_pending = 1'b0;
            n_prev_byte     = 8'd0;
            n_line_start    = 1'b1;
        end else begin
            if (r_quote_pending) begin
                n_quote_pending = 1'b0;
                if (i_byte_req == QUOTE_BYTE) begin
                    // doubled quote inside a quoted cell
                    w_res_valid = 1'b1;
                    w_kind      = KIND_BYTE;
                    w_value     = QUOTE_BYTE;
                    w_done      = 1'b1;
                end else begin
                    w_inq = 1'b0;
                end
            end
            if (!w_done) begin
                n_in_quotes = w_inq;
                if (i_byte_req == QUOTE_BYTE) begin
                    if (r_line_start || (!w_inq && r_prev_byte == r_delimiter)) begin
                        n_in_quotes = 1'b1;
                    end else begin
                        n_quote_pending = 1'b1;
                    end
                end else if (i_byte_req == r_delimiter && !w_inq) begin
                    w_res_valid = 1'b1;
                    w_kind      = KIND_CELL_END;
                end else begin
                    w_res_valid = 1'b1;
                    w_kind      = KIND_BYTE;
                    w_value     = i_byte_req;
                end
            end
            n_prev_byte  = i_byte_req;
            n_line_start = 1'b0;
        end
    end

    // a request with no result never waits for the output register
    assign o_consume      = i_valid && (!w_res_valid || i_out_free);
    assign o_result.load  = o_consume && w_res_valid;
    assign o_result.kind  = w_kind;
    assign o_result.value = w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter     <= DELIMITER_RST;
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_prev_byte     <= 8'd0;
            r_line_start    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_delimiter <= i_cfg_data;
            end
            if (o_consume) begin
                r_in_quotes     <= n_in_quotes;
                r_quote_pending <= n_quote_pending;
                r_prev_byte     <= n_prev_byte;
                r_line_start    <= n_line_start;
            end
        end
    end

endmodule

@@ sv/dsvfs_out_reg.sv @@
// result register toward the receiver
module dsvfs_out_reg import dsvfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_result    i_result,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value
);

    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_value;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_kind  <= i_result.kind;
            r_value <= i_result.value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = 2'(r_kind);
    assign o_value = r_value;

endmodule

@@ sv/dsvfs_top.sv @@
// top level of the delimiter-separated value splitter
//
// input channel: i_valid / o_stall with i_action (0 byte, 1 end of source)
// and i_byte_req; a request is taken at a clock edge with i_valid high and
// o_stall low. output channel: o_valid / i_stall with o_kind (0 cell byte,
// 1 end of cell, 2 end of row) and o_value (the byte, zero otherwise).
// each request gives zero or one result.
// a request sits in the input register; the parse decision and state
// update are made from it and registered into the result register,
// which drives the outputs.
// throughput is one request per cycle while i_stall is low; the quote and
// row state update is a single short step; only i_stall holds back bytes.
// i_cfg_we with i_cfg_data writes the delimiter (reset value ','); write it
// only while no request is in flight.
// synchronous active-low reset empties both registers, sets the delimiter
// to ',' and starts a fresh row outside quotes.
// while i_stall holds, the result stays put; one more request can wait in
// the input register, requests with no result still pass, and then o_stall
// rises.
module dsv_field_splitter_top import dsvfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_byte_req,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value
);

    logic       w_in_valid;
    t_action    w_in_action;
    logic [7:0] w_in_byte;
    logic       w_consume;
    logic       w_out_free;
    t_result    w_result;

    dsvfs_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_byte_req (i_byte_req),
        .i_consume  (w_consume),
        .o_valid    (w_in_valid),
        .o_action   (w_in_action),
        .o_byte_req (w_in_byte)
    );

    dsvfs_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_in_valid),
        .i_action   (w_in_action),
        .i_byte_req (w_in_byte),
        .i_out_free (w_out_free),
        .o_consume  (w_consume),
        .o_result   (w_result)
    );

    dsvfs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_kind   (o_kind),
        .o_value  (o_value)
    );

    // a taken request is held in the input register next cycle
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_in_valid)
        else $error("accepted request lost from input register");

    // marker results always carry a zero value
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != 2'(KIND_BYTE)) |-> (o_value == 8'd0))
        else $error("marker result with nonzero value");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind != 2'd3))
        else $error("illegal result kind");

    // the result register never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_result.load)
        else $error("result overwritten while stalled");

endmodule
